// File: hdl/gmt_pkg.sv
// Shared types and constants for the gated multichannel tachometer.
// Used by the controller, the datapath and the top level; depends on nothing.
package gmt_pkg;

   localparam logic [15:0] MS_PER_MINUTE = 16'd60000;
   localparam logic [15:0] RPM_MAX       = 16'hFFFF;
   localparam logic [23:0] TRAVEL_MAX    = 24'hFFFFFF;

   localparam logic [15:0] GATE_MS_RESET      = 16'd1000;
   localparam logic [7:0]  WHEEL_TEETH_RESET  = 8'd1;
   localparam logic [7:0]  ENGINE_TEETH_RESET = 8'd1;
   localparam logic [15:0] MAX_RPM_RESET      = 16'hFFFF;

   // Register indexes on the csr port
   localparam logic [1:0] CSR_GATE_MS      = 2'd0;
   localparam logic [1:0] CSR_WHEEL_TEETH  = 2'd1;
   localparam logic [1:0] CSR_ENGINE_TEETH = 2'd2;
   localparam logic [1:0] CSR_MAX_RPM      = 2'd3;

   // Channel codes, also the order of evaluation
   localparam logic [1:0] CH_TURBINE_A = 2'd0;
   localparam logic [1:0] CH_TURBINE_B = 2'd1;
   localparam logic [1:0] CH_WHEEL     = 2'd2;
   localparam logic [1:0] CH_ENGINE    = 2'd3;

   typedef struct packed {
      logic turbine_a_pulse;
      logic turbine_b_pulse;
      logic wheel_pulse;
      logic engine_pulse;
      logic ms_tick;
   } req_type;

   typedef struct packed {
      logic [15:0] turbine_a_rpm;
      logic [15:0] turbine_b_rpm;
      logic [15:0] wheel_rpm;
      logic [15:0] engine_rpm;
      logic [23:0] wheel_travel_revs;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_COUNT,
      ST_REVS_LOAD,
      ST_REVS_DIV,
      ST_RPM_LOAD,
      ST_RPM_DIV,
      ST_RPM_STORE,
      ST_OUT
   } ctrl_state_type;

   typedef struct packed {
      logic       count_en;
      logic       revs_load;
      logic       div_step;
      logic       rpm_load;
      logic       rpm_store;
      logic       load_out;
      logic [1:0] chan;
   } cmd_type;

   typedef struct packed {
      logic close;
   } status_type;

endpackage

// File: hdl/gmt_ctrl.sv
// Sequencer for the tachometer: accepts count beats, walks the four
// channels through the shared divider on window close, owns rsp_valid.
// Depends on gmt_pkg.
module gmt_ctrl
   import gmt_pkg::*;
#(
   parameter int DIV_STEPS = 40
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam int STEP_W = $clog2(DIV_STEPS);

   ctrl_state_type    state_ff, state_in;
   logic [1:0]        chan_ff, chan_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              last_step;
   logic              out_free;

   assign last_step = (step_ff == STEP_W'(DIV_STEPS - 1));
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_COUNT: begin
            if (req_valid && status.close) state_in = ST_REVS_LOAD;
         end
         ST_REVS_LOAD: state_in = ST_REVS_DIV;
         ST_REVS_DIV: begin
            if (last_step) state_in = ST_RPM_LOAD;
         end
         ST_RPM_LOAD: state_in = ST_RPM_DIV;
         ST_RPM_DIV: begin
            if (last_step) state_in = ST_RPM_STORE;
         end
         ST_RPM_STORE: begin
            if (chan_ff == CH_ENGINE) state_in = ST_OUT;
            else state_in = ST_REVS_LOAD;
         end
         ST_OUT: begin
            if (out_free) state_in = ST_COUNT;
         end
         default: state_in = ST_COUNT;
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.chan      = chan_ff;
      unique case (state_ff)
         ST_COUNT: begin
            req_ready    = 1'b1;
            cmd.count_en = req_valid && !status.close;
         end
         ST_REVS_LOAD: cmd.revs_load = 1'b1;
         ST_REVS_DIV:  cmd.div_step  = 1'b1;
         ST_RPM_LOAD:  cmd.rpm_load  = 1'b1;
         ST_RPM_DIV:   cmd.div_step  = 1'b1;
         ST_RPM_STORE: cmd.rpm_store = 1'b1;
         ST_OUT:       cmd.load_out  = out_free;
         default: ;
      endcase
   end

   always_comb begin
      chan_in = chan_ff;
      step_in = '0;
      if (state_ff == ST_COUNT) chan_in = CH_TURBINE_A;
      if (state_ff == ST_RPM_STORE) chan_in = chan_ff + 2'd1;
      if ((state_ff == ST_REVS_DIV || state_ff == ST_RPM_DIV) && !last_step) begin
         step_in = step_ff + STEP_W'(1);
      end
      // drop valid when taken, set it when a fresh result lands
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.load_out) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COUNT;
         chan_ff      <= CH_TURBINE_A;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chan_ff      <= chan_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: hdl/gmt_dp.sv
// Datapath of the tachometer: config registers, saturating pulse counters,
// tick counter, shared restoring divider and the result register.
// Depends on gmt_pkg.
module gmt_dp
   import gmt_pkg::*;
#(
   parameter int TURBINE_PULSES_PER_REV = 60,
   parameter int COUNT_BITS             = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  req_type     req_data,
   output rsp_type     rsp_data,
   input  cmd_type     cmd,
   output status_type  status
);

   localparam int DIVW = COUNT_BITS + 16;

   logic [15:0] gate_ms_ff, gate_ms_in;
   logic [7:0]  wheel_teeth_ff, wheel_teeth_in;
   logic [7:0]  engine_teeth_ff, engine_teeth_in;
   logic [15:0] max_rpm_ff, max_rpm_in;

   logic [COUNT_BITS-1:0] count_ff [4];
   logic [COUNT_BITS-1:0] count_in [4];
   logic [3:0]            pulse;
   logic [15:0]           elapsed_ff, elapsed_in;
   logic [23:0]           travel_ff, travel_in;

   logic [15:0]     gate_eff, wheel_div, engine_div, revs_div;
   logic [15:0]     rem_ff, rem_in;
   logic [DIVW-1:0] quo_ff, quo_in;
   logic [15:0]     dvs_ff, dvs_in;
   logic [16:0]     rem_wide;
   logic            fits;
   logic [DIVW-1:0] product;
   logic [15:0]     rpm_sat, rpm_final;
   logic [15:0]     rpm_ff [4];
   rsp_type         rsp_ff;

   // zero in a divisor register acts as one
   assign gate_eff   = (gate_ms_ff == 16'd0) ? 16'd1 : gate_ms_ff;
   assign wheel_div  = (wheel_teeth_ff == 8'd0) ? 16'd1 : {8'd0, wheel_teeth_ff};
   assign engine_div = (engine_teeth_ff == 8'd0) ? 16'd1 : {8'd0, engine_teeth_ff};

   assign status.close = req_data.ms_tick &&
                         ({1'b0, elapsed_ff} + 17'd1 >= {1'b0, gate_eff});

   always_comb begin
      gate_ms_in      = gate_ms_ff;
      wheel_teeth_in  = wheel_teeth_ff;
      engine_teeth_in = engine_teeth_ff;
      max_rpm_in      = max_rpm_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_GATE_MS:      gate_ms_in      = csr_wdata;
            CSR_WHEEL_TEETH:  wheel_teeth_in  = csr_wdata[7:0];
            CSR_ENGINE_TEETH: engine_teeth_in = csr_wdata[7:0];
            CSR_MAX_RPM:      max_rpm_in      = csr_wdata;
         endcase
      end
   end

   assign pulse = {req_data.engine_pulse, req_data.wheel_pulse,
                   req_data.turbine_b_pulse, req_data.turbine_a_pulse};

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         count_in[i] = count_ff[i];
         if (cmd.count_en && pulse[i] && (count_ff[i] != '1)) begin
            count_in[i] = count_ff[i] + COUNT_BITS'(1);
         end
         if (cmd.load_out) count_in[i] = '0;
      end
      elapsed_in = elapsed_ff;
      if (cmd.count_en && req_data.ms_tick) elapsed_in = elapsed_ff + 16'd1;
      if (cmd.load_out) elapsed_in = '0;
   end

   // Divider: one quotient bit per step, dividend shifts out of quo_ff
   always_comb begin
      unique case (cmd.chan)
         CH_TURBINE_A, CH_TURBINE_B: revs_div = 16'(TURBINE_PULSES_PER_REV);
         CH_WHEEL:                   revs_div = wheel_div;
         CH_ENGINE:                  revs_div = engine_div;
      endcase
   end

   assign rem_wide = {rem_ff, quo_ff[DIVW-1]};
   assign fits     = (rem_wide >= {1'b0, dvs_ff});
   assign product  = DIVW'(quo_ff[COUNT_BITS-1:0]) * DIVW'(MS_PER_MINUTE);

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      travel_in = travel_ff;
      if (cmd.revs_load) begin
         rem_in = '0;
         quo_in = DIVW'(count_ff[cmd.chan]);
         dvs_in = revs_div;
      end
      if (cmd.div_step) begin
         rem_in = fits ? 16'(rem_wide - {1'b0, dvs_ff}) : rem_wide[15:0];
         quo_in = {quo_ff[DIVW-2:0], fits};
      end
      if (cmd.rpm_load) begin
         rem_in = '0;
         quo_in = product;
         dvs_in = gate_eff;
         // hold travel unless a whole wheel revolution was seen
         if (cmd.chan == CH_WHEEL && quo_ff != '0) begin
            travel_in = (quo_ff > DIVW'(TRAVEL_MAX)) ? TRAVEL_MAX : quo_ff[23:0];
         end
      end
   end

   assign rpm_sat   = (quo_ff > DIVW'(RPM_MAX)) ? RPM_MAX : quo_ff[15:0];
   assign rpm_final = (cmd.chan == CH_ENGINE && rpm_sat > max_rpm_ff) ? max_rpm_ff : rpm_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         gate_ms_ff      <= GATE_MS_RESET;
         wheel_teeth_ff  <= WHEEL_TEETH_RESET;
         engine_teeth_ff <= ENGINE_TEETH_RESET;
         max_rpm_ff      <= MAX_RPM_RESET;
         for (int i = 0; i < 4; i++) count_ff[i] <= '0;
         elapsed_ff      <= '0;
         travel_ff       <= '0;
      end else begin
         gate_ms_ff      <= gate_ms_in;
         wheel_teeth_ff  <= wheel_teeth_in;
         engine_teeth_ff <= engine_teeth_in;
         max_rpm_ff      <= max_rpm_in;
         for (int i = 0; i < 4; i++) count_ff[i] <= count_in[i];
         elapsed_ff      <= elapsed_in;
         travel_ff       <= travel_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      if (cmd.rpm_store) rpm_ff[cmd.chan] <= rpm_final;
      if (cmd.load_out) begin
         rsp_ff.turbine_a_rpm     <= rpm_ff[CH_TURBINE_A];
         rsp_ff.turbine_b_rpm     <= rpm_ff[CH_TURBINE_B];
         rsp_ff.wheel_rpm         <= rpm_ff[CH_WHEEL];
         rsp_ff.engine_rpm        <= rpm_ff[CH_ENGINE];
         rsp_ff.wheel_travel_revs <= travel_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// File: hdl/gated_multichannel_tachometer_unit.sv
// Gated four-channel tachometer. Each req beat carries one edge flag per
// channel and a millisecond tick; beats that do not close the gate window are
// taken one per clock. The beat whose tick completes gate_ms ticks closes the
// window: its pulses are dropped, and the four counts go one channel at a time
// through a single restoring divider (one quotient bit per clock), first
// count / teeth (pulses per rev on turbines), then revs * 60000 / gate_ms.
// After a closing beat req_ready stays low until all four channels are done
// and the result is loaded, which also waits for the previous rsp beat to be
// taken. The result then sits in an output register while counting resumes.
// Configuration registers: 0 gate_ms, 1 wheel_teeth, 2 engine_teeth, 3 max_rpm.
module gated_multichannel_tachometer_unit
   import gmt_pkg::*;
#(
   parameter int TURBINE_PULSES_PER_REV = 60,
   parameter int COUNT_BITS             = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data
);

   cmd_type    cmd;
   status_type status;

   gmt_ctrl #(
      .DIV_STEPS (COUNT_BITS + 16)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   gmt_dp #(
      .TURBINE_PULSES_PER_REV (TURBINE_PULSES_PER_REV),
      .COUNT_BITS             (COUNT_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule
